// ===== hdl/lru_block_cache_directory_macros.svh =====
// Assertion macros shared by the cache directory RTL.
`ifndef LRU_BLOCK_CACHE_DIRECTORY_MACROS_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked only out of reset.
`define LBCD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache directory check failed");
// Next-cycle implication, checked only out of reset.
`define LBCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache directory check failed");
`else
`define LBCD_ASSERT_IMPL(label, ante, cons)
`define LBCD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/lbcd_pkg.sv =====
`default_nettype none
package lbcd_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int TABLE_BITS_DEF = 8;
  localparam int BLOCK_BITS_DEF = 32;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;
  localparam logic [1:0] KIND_INVAL = 2'd3;

  localparam logic [2:0] ACT_HIT    = 3'd0;
  localparam logic [2:0] ACT_FILL   = 3'd1;
  localparam logic [2:0] ACT_WBACK  = 3'd2;
  localparam logic [2:0] ACT_BYPASS = 3'd3;
  localparam logic [2:0] ACT_DONE   = 3'd4;
  localparam logic [2:0] ACT_ERROR  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_ADDR, S_CMP, S_KEEP, S_GONE, S_COPY, S_HIT, S_FILL, S_FINAL
  } state_t;

  // What the current walk over the recency order is doing.
  typedef enum logic [2:0] {
    M_CHG, M_LOOK, M_VFL, M_FLUSH, M_MARK
  } mode_t;

endpackage
`default_nettype wire

// ===== hdl/lbcd_ram.sv =====
`default_nettype none
module lbcd_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/lru_block_cache_directory.sv =====
// Directory of a fully associative write-back block cache with LRU replacement.
// Input transfers on in_* carry one request: read, write, flush or invalidate.
// Each request answers with one or more command transfers on out_*; the last
// one of a request has out_tlast high. Write-back commands come first, in
// most-recent order, followed by the hit, fill, bypass, done or error command.
// The slot tags sit in a RAM with a registered read; the recency walk reads
// one slot at a time, with an address state before each compare. A lookup
// whose dirty victim needs a write-back sends the walk around again, and a
// request on a changed table first writes back and drops that table's slots.
// Bypass and error requests skip the walk.
// One request is in work at a time; in_tready is high only between requests.
// The output register lets a new request enter while the last command waits.
// When the receiver holds out_tready low, the walk stops at the next command
// and resumes after that command is taken; nothing is dropped.
// After reset all slots are invalid and clean, and the recency order runs from
// slot 0 (most recent) to the last slot. No clearing pass is needed.
`default_nettype none
`include "lru_block_cache_directory_macros.svh"
module lru_block_cache_directory #(
  parameter int SLOTS      = lbcd_pkg::SLOTS_DEF,
  parameter int TABLE_BITS = lbcd_pkg::TABLE_BITS_DEF,
  parameter int BLOCK_BITS = lbcd_pkg::BLOCK_BITS_DEF,
  localparam int SW    = $clog2(SLOTS),
  localparam int IN_W  = ((TABLE_BITS + BLOCK_BITS + 4) + 7) / 8 * 8,
  localparam int OUT_W = ((SW + TABLE_BITS + BLOCK_BITS + 1) + 7) / 8 * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // table_handle, is_index, block_number, exclusive_mode, index_changed, flush_all
  input  wire logic [IN_W-1:0]  in_tdata,
  // kind
  input  wire logic [1:0]       in_tuser,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // slot, out_table, out_is_index, out_block
  output logic      [OUT_W-1:0] out_tdata,
  // action
  output logic      [2:0]       out_tuser,
  output logic                  out_tlast
);

  localparam int TAG_W = TABLE_BITS + 1 + BLOCK_BITS;
  localparam int TB = TABLE_BITS;
  localparam int BB = BLOCK_BITS;

  lbcd_pkg::state_t state_r, state_nxt;
  lbcd_pkg::mode_t  mode_r, mode_nxt;

  logic [SW-1:0]   order_r [SLOTS];
  logic [SW-1:0]   new_r   [SLOTS];
  logic [SLOTS-1:0] valid_r, dirty_r, gone_r;
  logic [SW-1:0]   pos_r, nk_r;

  logic [1:0]      kind_r;
  logic [TB-1:0]   tbl_r, vtbl_r;
  logic            idx_r, all_r;
  logic [BB-1:0]   blk_r;
  logic [2:0]      fin_act_r;
  logic            fin_idx_r;
  logic [BB-1:0]   fin_blk_r;

  logic            out_vld_r, out_last_r, out_idx_r;
  logic [2:0]      out_act_r;
  logic [SW-1:0]   out_slot_r;
  logic [TB-1:0]   out_tbl_r;
  logic [BB-1:0]   out_blk_r;

  logic [TAG_W-1:0] rdata;

  // Input unpacking.
  logic          in_acc;
  logic [TB-1:0] in_tbl;
  logic          in_idx, in_excl, in_chg, in_all;
  logic [BB-1:0] in_blk;

  assign in_acc  = in_tvalid & in_tready;
  assign in_tbl  = in_tdata[TB-1:0];
  assign in_idx  = in_tdata[TB];
  assign in_blk  = in_tdata[TB+BB:TB+1];
  assign in_excl = in_tdata[TB+BB+1];
  assign in_chg  = in_tdata[TB+BB+2];
  assign in_all  = in_tdata[TB+BB+3];

  // Walk datapath.
  logic [SW-1:0] s_cur, victim;
  logic          pos_last, can_emit, tmatch, sel_hit, wb_want, look_hit, stall;
  logic [TB-1:0] r_tbl, cmp_tbl;
  logic          r_idx;
  logic [BB-1:0] r_blk;

  assign s_cur    = order_r[pos_r];
  assign victim   = order_r[SLOTS-1];
  assign pos_last = (pos_r == SW'(SLOTS - 1));
  assign can_emit = !out_vld_r || out_tready;
  assign r_tbl    = rdata[TB-1:0];
  assign r_idx    = rdata[TB];
  assign r_blk    = rdata[TAG_W-1:TB+1];
  assign cmp_tbl  = (mode_r == lbcd_pkg::M_VFL) ? vtbl_r : tbl_r;
  assign tmatch   = (r_tbl == cmp_tbl);
  assign sel_hit  = valid_r[s_cur] && tmatch;

  always_comb begin
    wb_want  = 1'b0;
    look_hit = 1'b0;
    if (state_r == lbcd_pkg::S_CMP) begin
      case (mode_r)
        lbcd_pkg::M_CHG, lbcd_pkg::M_VFL: wb_want = dirty_r[s_cur] && tmatch;
        lbcd_pkg::M_FLUSH: wb_want = dirty_r[s_cur] && (all_r || tmatch);
        lbcd_pkg::M_LOOK: look_hit = sel_hit && (r_idx == idx_r) && (r_blk == blk_r);
        default: wb_want = 1'b0;
      endcase
    end
  end
  assign stall = wb_want && !can_emit;

  // Next state and walk mode.
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    case (state_r)
      lbcd_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == lbcd_pkg::KIND_FLUSH) begin
            state_nxt = lbcd_pkg::S_ADDR;
            mode_nxt  = lbcd_pkg::M_FLUSH;
          end else if (in_tuser == lbcd_pkg::KIND_INVAL) begin
            state_nxt = lbcd_pkg::S_ADDR;
            mode_nxt  = lbcd_pkg::M_MARK;
          end else if ((in_tuser == lbcd_pkg::KIND_WRITE && in_blk == '0) ||
                       (in_idx && in_blk == BB'(1) && !in_excl)) begin
            state_nxt = lbcd_pkg::S_FINAL;
          end else begin
            state_nxt = lbcd_pkg::S_ADDR;
            mode_nxt  = in_chg ? lbcd_pkg::M_CHG : lbcd_pkg::M_LOOK;
          end
        end
      end
      lbcd_pkg::S_ADDR: state_nxt = lbcd_pkg::S_CMP;
      lbcd_pkg::S_CMP: begin
        if (!stall) begin
          if (look_hit) begin
            state_nxt = lbcd_pkg::S_HIT;
          end else if (!pos_last) begin
            state_nxt = lbcd_pkg::S_ADDR;
          end else begin
            case (mode_r)
              lbcd_pkg::M_CHG, lbcd_pkg::M_MARK: state_nxt = lbcd_pkg::S_KEEP;
              lbcd_pkg::M_FLUSH: state_nxt = lbcd_pkg::S_FINAL;
              lbcd_pkg::M_VFL: state_nxt = lbcd_pkg::S_FILL;
              default: begin
                if (dirty_r[s_cur]) begin
                  state_nxt = lbcd_pkg::S_ADDR;
                  mode_nxt  = lbcd_pkg::M_VFL;
                end else begin
                  state_nxt = lbcd_pkg::S_FILL;
                end
              end
            endcase
          end
        end
      end
      lbcd_pkg::S_KEEP: if (pos_last) state_nxt = lbcd_pkg::S_GONE;
      lbcd_pkg::S_GONE: if (pos_last) state_nxt = lbcd_pkg::S_COPY;
      lbcd_pkg::S_COPY: begin
        if (mode_r == lbcd_pkg::M_CHG) begin
          state_nxt = lbcd_pkg::S_ADDR;
          mode_nxt  = lbcd_pkg::M_LOOK;
        end else begin
          state_nxt = lbcd_pkg::S_FINAL;
        end
      end
      lbcd_pkg::S_HIT, lbcd_pkg::S_FILL, lbcd_pkg::S_FINAL: begin
        if (can_emit) state_nxt = lbcd_pkg::S_IDLE;
      end
      default: state_nxt = lbcd_pkg::S_IDLE;
    endcase
  end

  // Result emission and write controls.
  logic          emit, e_last, e_idx, ram_we;
  logic [2:0]    e_act;
  logic [SW-1:0] e_slot, front_slot, front_pos;
  logic [TB-1:0] e_tbl;
  logic [BB-1:0] e_blk;
  logic          do_front;

  always_comb begin
    emit       = 1'b0;
    e_last     = 1'b0;
    e_act      = lbcd_pkg::ACT_DONE;
    e_slot     = '0;
    e_tbl      = tbl_r;
    e_idx      = 1'b0;
    e_blk      = '0;
    ram_we     = 1'b0;
    do_front   = 1'b0;
    front_slot = s_cur;
    front_pos  = pos_r;
    case (state_r)
      lbcd_pkg::S_CMP: begin
        if (wb_want && can_emit) begin
          emit   = 1'b1;
          e_act  = lbcd_pkg::ACT_WBACK;
          e_slot = s_cur;
          e_tbl  = r_tbl;
          e_idx  = r_idx;
          e_blk  = r_blk;
        end
      end
      lbcd_pkg::S_HIT: begin
        emit     = can_emit;
        e_last   = 1'b1;
        e_act    = lbcd_pkg::ACT_HIT;
        e_slot   = s_cur;
        e_idx    = idx_r;
        e_blk    = blk_r;
        do_front = can_emit;
      end
      lbcd_pkg::S_FILL: begin
        emit       = can_emit;
        e_last     = 1'b1;
        e_act      = (kind_r == lbcd_pkg::KIND_WRITE) ? lbcd_pkg::ACT_DONE
                                                      : lbcd_pkg::ACT_FILL;
        e_slot     = victim;
        e_idx      = idx_r;
        e_blk      = blk_r;
        ram_we     = can_emit;
        do_front   = can_emit;
        front_slot = victim;
        front_pos  = SW'(SLOTS - 1);
      end
      lbcd_pkg::S_FINAL: begin
        emit   = can_emit;
        e_last = 1'b1;
        e_act  = fin_act_r;
        e_idx  = fin_idx_r;
        e_blk  = fin_blk_r;
      end
      default: emit = 1'b0;
    endcase
  end

  // Move-to-front of the entry at front_pos.
  logic [SW-1:0] front_order [SLOTS];
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (i == 0) begin
        front_order[i] = front_slot;
      end else if (SW'(i) <= front_pos) begin
        front_order[i] = order_r[i-1];
      end else begin
        front_order[i] = order_r[i];
      end
    end
  end

  logic walk_step, pass_step;
  assign walk_step = (state_r == lbcd_pkg::S_CMP) && !stall && !look_hit;
  assign pass_step = (state_r == lbcd_pkg::S_KEEP) || (state_r == lbcd_pkg::S_GONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lbcd_pkg::S_IDLE;
      mode_r    <= lbcd_pkg::M_LOOK;
      valid_r   <= '0;
      dirty_r   <= '0;
      out_vld_r <= 1'b0;
      pos_r     <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        order_r[i] <= SW'(i);
      end
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (in_acc) begin
        pos_r <= '0;
      end else if (walk_step || pass_step) begin
        pos_r <= pos_last ? '0 : pos_r + SW'(1);
      end
      if (state_r == lbcd_pkg::S_CMP && !stall) begin
        if ((mode_r == lbcd_pkg::M_CHG || mode_r == lbcd_pkg::M_MARK) && sel_hit) begin
          valid_r[s_cur] <= 1'b0;
          dirty_r[s_cur] <= 1'b0;
        end else if (wb_want) begin
          dirty_r[s_cur] <= 1'b0;
        end
      end
      if (state_r == lbcd_pkg::S_HIT && can_emit && kind_r == lbcd_pkg::KIND_WRITE) begin
        dirty_r[s_cur] <= 1'b1;
      end
      if (state_r == lbcd_pkg::S_FILL && can_emit) begin
        valid_r[victim] <= 1'b1;
        dirty_r[victim] <= (kind_r == lbcd_pkg::KIND_WRITE);
      end
      if (do_front) begin
        order_r <= front_order;
      end else if (state_r == lbcd_pkg::S_COPY) begin
        order_r <= new_r;
      end
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r    <= in_tuser;
      tbl_r     <= in_tbl;
      idx_r     <= in_idx;
      blk_r     <= in_blk;
      all_r     <= in_all;
      gone_r    <= '0;
      if (in_tuser == lbcd_pkg::KIND_FLUSH || in_tuser == lbcd_pkg::KIND_INVAL) begin
        fin_act_r <= lbcd_pkg::ACT_DONE;
        fin_idx_r <= 1'b0;
        fin_blk_r <= '0;
      end else if (in_tuser == lbcd_pkg::KIND_WRITE && in_blk == '0) begin
        fin_act_r <= lbcd_pkg::ACT_ERROR;
        fin_idx_r <= in_idx;
        fin_blk_r <= in_blk;
      end else begin
        fin_act_r <= lbcd_pkg::ACT_BYPASS;
        fin_idx_r <= in_idx;
        fin_blk_r <= in_blk;
      end
    end
    if (state_r == lbcd_pkg::S_CMP && !stall &&
        (mode_r == lbcd_pkg::M_CHG || mode_r == lbcd_pkg::M_MARK) && sel_hit) begin
      gone_r[s_cur] <= 1'b1;
    end
    if (state_r == lbcd_pkg::S_CMP && mode_r == lbcd_pkg::M_LOOK && pos_last) begin
      vtbl_r <= r_tbl;
    end
    // Stable partition: surviving slots first, invalidated ones behind them.
    if (state_r == lbcd_pkg::S_CMP) begin
      nk_r <= '0;
    end else if ((state_r == lbcd_pkg::S_KEEP && !gone_r[s_cur]) ||
                 (state_r == lbcd_pkg::S_GONE && gone_r[s_cur])) begin
      new_r[nk_r] <= s_cur;
      nk_r        <= nk_r + SW'(1);
    end
    if (emit) begin
      out_act_r  <= e_act;
      out_slot_r <= e_slot;
      out_tbl_r  <= e_tbl;
      out_idx_r  <= e_idx;
      out_blk_r  <= e_blk;
      out_last_r <= e_last;
    end
  end

  lbcd_ram #(
    .WIDTH(TAG_W),
    .DEPTH(SLOTS)
  ) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(victim),
    .wdata({blk_r, idx_r, tbl_r}),
    .raddr(s_cur),
    .rdata(rdata)
  );

  assign in_tready  = (state_r == lbcd_pkg::S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_blk_r, out_idx_r, out_tbl_r, out_slot_r});

  `LBCD_ASSERT_IMPL(a_dirty_is_valid, 1'b1, (dirty_r & ~valid_r) == '0)
  `LBCD_ASSERT_NEXT(a_last_to_idle, emit && e_last, state_r == lbcd_pkg::S_IDLE)
  `LBCD_ASSERT_NEXT(a_fill_front, state_r == lbcd_pkg::S_FILL && can_emit,
                    order_r[0] == $past(victim) && valid_r[$past(victim)])

endmodule
`default_nettype wire

// ===== bench/tb_lru_block_cache_directory.sv =====
`timescale 1ns / 1ps
module tb_lru_block_cache_directory;

  localparam int NSLOT = 16;
  localparam int IN_W  = 48;
  localparam int OUT_W = 48;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tbl;
    logic        idx;
    logic [31:0] blk;
    logic        excl;
    logic        chg;
    logic        all;
  } req_t;

  localparam int REQ_W = $bits(req_t);

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [7:0]  tbl;
    logic        idx;
    logic [31:0] blk;
    logic        last;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;

  lru_block_cache_directory dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the directory.
  logic        c_valid [NSLOT];
  logic        c_dirty [NSLOT];
  logic [7:0]  c_tbl   [NSLOT];
  logic        c_idx   [NSLOT];
  logic [31:0] c_blk   [NSLOT];
  logic [3:0]  c_order [NSLOT];

  req_t pending_reqs[$];
  cmd_t expected_cmds[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;
  bit   hold_sender = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;

  task automatic push_cmd(logic [2:0] a, logic [3:0] s, logic [7:0] t, logic i,
                          logic [31:0] b);
    cmd_t c;
    c = '{action: a, slot: s, tbl: t, idx: i, blk: b, last: 1'b0};
    expected_cmds.push_back(c);
  endtask

  task automatic move_front(logic [3:0] s);
    int p;
    p = 0;
    while (p < NSLOT && c_order[p] != s) p++;
    for (; p > 0; p--) c_order[p] = c_order[p-1];
    c_order[0] = s;
  endtask

  task automatic write_back(bit every, logic [7:0] t);
    logic [3:0] s;
    for (int i = 0; i < NSLOT; i++) begin
      s = c_order[i];
      if (c_dirty[s] && (every || c_tbl[s] == t)) begin
        push_cmd(lbcd_pkg::ACT_WBACK, s, c_tbl[s], c_idx[s], c_blk[s]);
        c_dirty[s] = 1'b0;
      end
    end
  endtask

  task automatic drop_table(logic [7:0] t);
    logic [3:0] keep[$];
    logic [3:0] gone[$];
    logic [3:0] s;
    for (int i = 0; i < NSLOT; i++) begin
      s = c_order[i];
      if (c_valid[s] && c_tbl[s] == t) begin
        c_valid[s] = 1'b0;
        c_dirty[s] = 1'b0;
        gone.push_back(s);
      end else keep.push_back(s);
    end
    foreach (keep[i]) c_order[i] = keep[i];
    foreach (gone[i]) c_order[keep.size() + i] = gone[i];
  endtask

  task automatic predict_directory(req_t r);
    logic [3:0] s;
    int hit;
    if (r.kind == lbcd_pkg::KIND_FLUSH) begin
      write_back(r.all, r.tbl);
      push_cmd(lbcd_pkg::ACT_DONE, 4'd0, r.tbl, 1'b0, '0);
    end else if (r.kind == lbcd_pkg::KIND_INVAL) begin
      drop_table(r.tbl);
      push_cmd(lbcd_pkg::ACT_DONE, 4'd0, r.tbl, 1'b0, '0);
    end else if (r.kind == lbcd_pkg::KIND_WRITE && r.blk == 0) begin
      push_cmd(lbcd_pkg::ACT_ERROR, 4'd0, r.tbl, r.idx, r.blk);
    end else if (r.idx && r.blk == 1 && !r.excl) begin
      push_cmd(lbcd_pkg::ACT_BYPASS, 4'd0, r.tbl, r.idx, r.blk);
    end else begin
      if (r.chg) begin
        write_back(1'b0, r.tbl);
        drop_table(r.tbl);
      end
      hit = -1;
      for (int i = 0; i < NSLOT && hit < 0; i++) begin
        s = c_order[i];
        if (c_valid[s] && c_tbl[s] == r.tbl && c_idx[s] == r.idx && c_blk[s] == r.blk)
          hit = int'(s);
      end
      if (hit >= 0) begin
        if (r.kind == lbcd_pkg::KIND_WRITE) c_dirty[hit] = 1'b1;
        move_front(4'(hit));
        push_cmd(lbcd_pkg::ACT_HIT, 4'(hit), r.tbl, r.idx, r.blk);
      end else begin
        s = c_order[NSLOT-1];
        if (c_dirty[s]) write_back(1'b0, c_tbl[s]);
        c_valid[s] = 1'b1;
        c_dirty[s] = (r.kind == lbcd_pkg::KIND_WRITE);
        c_tbl[s] = r.tbl;
        c_idx[s] = r.idx;
        c_blk[s] = r.blk;
        move_front(s);
        push_cmd(r.kind == lbcd_pkg::KIND_WRITE ? lbcd_pkg::ACT_DONE : lbcd_pkg::ACT_FILL,
                 s, r.tbl, r.idx, r.blk);
      end
    end
    expected_cmds[$].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
  endtask

  // Driver.
  always @(posedge clk) begin
    req_t r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_directory(pending_reqs.pop_front());
        in_gap = quiet ? 0 : ($urandom_range(0, 5) == 0 ? $urandom_range(1, 3) : 0);
      end
      if (in_tvalid && !in_tready) begin
        // keep holding the item
      end else if (in_gap > 0 || hold_sender || pending_reqs.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_tvalid <= 1'b0;
      end else begin
        r = pending_reqs[0];
        in_tvalid <= 1'b1;
        in_tuser <= r.kind;
        in_tdata <= {4'b0, r.all, r.chg, r.excl, r.blk, r.idx, r.tbl};
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    cmd_t g;
    cmd_t w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        g = '{action: out_tuser, slot: out_tdata[3:0], tbl: out_tdata[11:4],
              idx: out_tdata[12], blk: out_tdata[44:13], last: out_tlast};
        if (expected_cmds.size() == 0) begin
          report_mismatch("unexpected command", 64'(g), 64'd0);
        end else begin
          w = expected_cmds.pop_front();
          if (g.action != w.action) report_mismatch("action", 64'(g.action), 64'(w.action));
          if (g.slot != w.slot) report_mismatch("slot", 64'(g.slot), 64'(w.slot));
          if (g.tbl != w.tbl) report_mismatch("table", 64'(g.tbl), 64'(w.tbl));
          if (g.idx != w.idx) report_mismatch("is_index", 64'(g.idx), 64'(w.idx));
          if (g.blk != w.blk) report_mismatch("block", 64'(g.blk), 64'(w.blk));
          if (g.last != w.last) report_mismatch("last", 64'(g.last), 64'(w.last));
        end
      end
      if (out_gap > 0 && !quiet) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else out_tready <= 1'b1;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic req_t make_req(logic [1:0] k, logic [7:0] t, logic i, logic [31:0] b,
                                    logic e, logic c, logic a);
    return '{kind: k, tbl: t, idx: i, blk: b, excl: e, chg: c, all: a};
  endfunction

  // Blocks come from a small pool so that hits, evictions and cascades happen.
  function automatic req_t random_req();
    req_t r;
    int pick;
    r = req_t'(REQ_W'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    r.tbl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 3));
    if ($urandom_range(0, 9) != 0) r.blk = $urandom_range(0, 12);
    r.chg = ($urandom_range(0, 15) == 0);
    if (pick < 45) r.kind = lbcd_pkg::KIND_READ;
    else if (pick < 85) r.kind = lbcd_pkg::KIND_WRITE;
    else if (pick < 93) r.kind = lbcd_pkg::KIND_FLUSH;
    else r.kind = lbcd_pkg::KIND_INVAL;
    return r;
  endfunction

  initial begin
    for (int s = 0; s < NSLOT; s++) begin
      c_valid[s] = 1'b0;
      c_dirty[s] = 1'b0;
      c_tbl[s] = '0;
      c_idx[s] = 1'b0;
      c_blk[s] = '0;
      c_order[s] = 4'(s);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    pending_reqs.push_back(make_req(lbcd_pkg::KIND_READ, 8'd0, 1'b0, 32'd0,
                                    1'b0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_WRITE, 8'd0, 1'b0, 32'd0,
                                    1'b0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_READ, 8'd1, 1'b1, 32'd1,
                                    1'b0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_WRITE, 8'd1, 1'b1, 32'd1,
                                    1'b1, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_READ, 8'd1, 1'b1, 32'd1,
                                    1'b1, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_WRITE, 8'hff, 1'b1, 32'hffffffff,
                                    1'b1, 1'b0, 1'b1));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_READ, 8'hff, 1'b1, 32'hffffffff,
                                    1'b0, 1'b0, 1'b0));
    for (int b = 2; b < 18; b++)
      pending_reqs.push_back(make_req(lbcd_pkg::KIND_WRITE, 8'd2, b[0], b,
                                      1'b0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_READ, 8'd2, 1'b0, 32'd40,
                                    1'b0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_WRITE, 8'd2, 1'b0, 32'd41,
                                    1'b0, 1'b1, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_WRITE, 8'd3, 1'b0, 32'd5,
                                    1'b0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_FLUSH, 8'd3, 1'b0, 32'd0,
                                    1'b0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_FLUSH, 8'd0, 1'b0, 32'd0,
                                    1'b0, 1'b1, 1'b1));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_INVAL, 8'd2, 1'b0, 32'd0,
                                    1'b0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(lbcd_pkg::KIND_READ, 8'd2, 1'b0, 32'd41,
                                    1'b0, 1'b0, 1'b0));

    wait (pending_reqs.size() == 0);
    // Let the directory drain completely before the random part.
    hold_sender = 1'b1;
    wait (expected_cmds.size() == 0);
    @(posedge clk);
    hold_sender = 1'b0;

    for (int n = 0; n < 350; n++) pending_reqs.push_back(random_req());
    wait (pending_reqs.size() == 0);
    quiet = 1'b1;
    for (int n = 0; n < 80; n++) pending_reqs.push_back(random_req());
    wait (pending_reqs.size() == 0);
    wait (expected_cmds.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/lbcd_pkg.sv
hdl/lbcd_ram.sv
hdl/lru_block_cache_directory.sv
bench/tb_lru_block_cache_directory.sv
